/* rtl/core/point_to_segment_distance_unit_defines.svh */
// Assertion helpers for the point-to-segment distance unit.
`ifndef POINT_TO_SEGMENT_DISTANCE_UNIT_DEFINES_SVH
`define POINT_TO_SEGMENT_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptsd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PTSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptsd: next-cycle check failed");

`endif

/* rtl/core/ptsd_pkg.sv */
package ptsd_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned SqBits    = 2 * DiffBits + 1;
  localparam int unsigned CrBits    = 2 * DiffBits;
  localparam int unsigned HalfBits  = CrBits / 2;
  localparam int unsigned Cr2Bits   = 2 * CrBits;
  localparam int unsigned QuoBits   = SqBits;
  localparam int unsigned RootBits  = (SqBits + 1) / 2;
  localparam int unsigned RadBits   = 2 * RootBits;
  localparam int unsigned DistBits  = 17;
  localparam logic [DistBits-1:0] DistMax = 17'h1ffff;
  localparam int unsigned RegIdxBits = 2;

  typedef enum logic [1:0] {
    PartPerp = 2'd0,
    PartEndA = 2'd1,
    PartEndB = 2'd2
  } part_e;

  typedef enum logic [RegIdxBits-1:0] {
    RegEndAX = 2'd0,
    RegEndAY = 2'd1,
    RegEndBX = 2'd2,
    RegEndBY = 2'd3
  } reg_idx_e;

  typedef struct packed {
    part_e              part;
    logic               band;
    logic [SqBits-1:0]  alt;
  } side_t;

endpackage

/* rtl/core/point_to_segment_distance_unit.sv */
// Channel   Direction  Handshake                 Payload
// query     in         in_valid_i / in_ready_o   query_x_i, query_y_i
// result    out        out_valid_o / out_ready_i seg_distance_o, nearest_part_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One query enters per cycle while no result waits; each query passes through the
// front stages, the one-bit-per-stage divider and square root, and the output register.
// The whole pipeline advances together: it holds only while a result waits.
// Reset clears the endpoints to zero and empties the pipeline.
`include "point_to_segment_distance_unit_defines.svh"

module point_to_segment_distance_unit import ptsd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [RegIdxBits-1:0]        cfg_index_i,
  input  logic [CoordBits-1:0]         cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CoordBits-1:0]  query_x_i,
  input  logic signed [CoordBits-1:0]  query_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DistBits-1:0]          seg_distance_o,
  output logic [1:0]                   nearest_part_o
);

  logic adv;
  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  // Endpoint registers
  logic signed [CoordBits-1:0] ax_q, ay_q, bx_q, by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
      ay_q <= '0;
      bx_q <= '0;
      by_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegEndAX: ax_q <= cfg_data_i;
        RegEndAY: ay_q <= cfg_data_i;
        RegEndBX: bx_q <= cfg_data_i;
        RegEndBY: by_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the front, divider and square-root stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic dv_q [QuoBits+1];
  logic sv_q [RootBits+1];

  // Stage 1: differences
  logic signed [DiffBits-1:0] dx_q, dy_q, px_q, py_q, ex_q, ey_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= $signed({bx_q[CoordBits-1], bx_q}) - $signed({ax_q[CoordBits-1], ax_q});
      dy_q <= $signed({by_q[CoordBits-1], by_q}) - $signed({ay_q[CoordBits-1], ay_q});
      px_q <= $signed({query_x_i[CoordBits-1], query_x_i})
              - $signed({ax_q[CoordBits-1], ax_q});
      py_q <= $signed({query_y_i[CoordBits-1], query_y_i})
              - $signed({ay_q[CoordBits-1], ay_q});
      ex_q <= $signed({query_x_i[CoordBits-1], query_x_i})
              - $signed({bx_q[CoordBits-1], bx_q});
      ey_q <= $signed({query_y_i[CoordBits-1], query_y_i})
              - $signed({by_q[CoordBits-1], by_q});
    end
  end

  // Stage 2: products
  logic signed [CrBits-1:0] sdx_q, sdy_q, spx_q, spy_q, sex_q, sey_q;
  logic signed [CrBits-1:0] dtx_q, dty_q, crl_q, crr_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sdx_q <= dx_q * dx_q;
      sdy_q <= dy_q * dy_q;
      spx_q <= px_q * px_q;
      spy_q <= py_q * py_q;
      sex_q <= ex_q * ex_q;
      sey_q <= ey_q * ey_q;
      dtx_q <= px_q * dx_q;
      dty_q <= py_q * dy_q;
      crl_q <= dx_q * py_q;
      crr_q <= dy_q * px_q;
    end
  end

  // Stage 3: sums
  logic [SqBits-1:0]        len2_q, da2_q, db2_q;
  logic signed [SqBits-1:0] dot_q, cr_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len2_q <= SqBits'($unsigned(sdx_q)) + SqBits'($unsigned(sdy_q));
      da2_q  <= SqBits'($unsigned(spx_q)) + SqBits'($unsigned(spy_q));
      db2_q  <= SqBits'($unsigned(sex_q)) + SqBits'($unsigned(sey_q));
      dot_q  <= $signed({dtx_q[CrBits-1], dtx_q}) + $signed({dty_q[CrBits-1], dty_q});
      cr_q   <= $signed({crl_q[CrBits-1], crl_q}) - $signed({crr_q[CrBits-1], crr_q});
    end
  end

  // Stage 4: band test and endpoint choice
  logic              band_d;
  part_e             part_d;
  logic [SqBits-1:0] cr_abs;
  side_t             side4_q;
  logic [SqBits-1:0] len2_4_q;
  logic [CrBits-1:0] crmag_q;

  always_comb begin
    band_d = (len2_q != '0) && !dot_q[SqBits-1] && ($unsigned(dot_q) <= len2_q);
    if (len2_q == '0)        part_d = PartEndA;
    else if (band_d)         part_d = PartPerp;
    else if (da2_q < db2_q)  part_d = PartEndA;
    else                     part_d = PartEndB;
    cr_abs = cr_q[SqBits-1] ? $unsigned(-cr_q) : $unsigned(cr_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q.part <= part_d;
      side4_q.band <= band_d;
      side4_q.alt  <= (part_d == PartEndB) ? db2_q : da2_q;
      len2_4_q     <= len2_q;
      crmag_q      <= cr_abs[CrBits-1:0];
    end
  end

  // Stage 5: partial products of cross squared
  side_t               side5_q;
  logic [SqBits-1:0]   len2_5_q;
  logic [2*HalfBits-1:0] pp_hh_q, pp_hl_q, pp_ll_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side5_q  <= side4_q;
      len2_5_q <= len2_4_q;
      pp_hh_q  <= crmag_q[CrBits-1:HalfBits] * crmag_q[CrBits-1:HalfBits];
      pp_hl_q  <= crmag_q[CrBits-1:HalfBits] * crmag_q[HalfBits-1:0];
      pp_ll_q  <= crmag_q[HalfBits-1:0] * crmag_q[HalfBits-1:0];
    end
  end

  logic [Cr2Bits-1:0] cr2;
  assign cr2 = {pp_hh_q, pp_ll_q} + (Cr2Bits'(pp_hl_q) << (HalfBits + 1));

  // Divider: one quotient bit per stage, floor(cross^2 / len2)
  logic [SqBits-1:0]  drem_q [QuoBits+1];
  logic [QuoBits-1:0] dlow_q [QuoBits+1];
  logic [QuoBits-1:0] dquo_q [QuoBits+1];
  logic [SqBits-1:0]  dlen_q [QuoBits+1];
  side_t              dside_q [QuoBits+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drem_q[0]  <= SqBits'(cr2[Cr2Bits-1:QuoBits]);
      dlow_q[0]  <= cr2[QuoBits-1:0];
      dquo_q[0]  <= '0;
      dlen_q[0]  <= len2_5_q;
      dside_q[0] <= side5_q;
    end
  end

  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    logic [SqBits:0] trem;
    logic            ge;
    logic [SqBits:0] nrem;

    always_comb begin
      trem = {drem_q[k], dlow_q[k][QuoBits-1]};
      ge   = trem >= {1'b0, dlen_q[k]};
      nrem = ge ? trem - {1'b0, dlen_q[k]} : trem;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        drem_q[k+1]  <= nrem[SqBits-1:0];
        dlow_q[k+1]  <= dlow_q[k] << 1;
        dquo_q[k+1]  <= {dquo_q[k][QuoBits-2:0], ge};
        dlen_q[k+1]  <= dlen_q[k];
        dside_q[k+1] <= dside_q[k];
      end
    end
  end

  // Square root: one root bit per stage
  logic [RadBits-1:0]  srad_q  [RootBits+1];
  logic [RootBits-1:0] sroot_q [RootBits+1];
  logic [RootBits+1:0] srem_q  [RootBits+1];
  part_e               spart_q [RootBits+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      srad_q[0]  <= RadBits'(dside_q[QuoBits].band ? dquo_q[QuoBits]
                                                  : dside_q[QuoBits].alt);
      sroot_q[0] <= '0;
      srem_q[0]  <= '0;
      spart_q[0] <= dside_q[QuoBits].part;
    end
  end

  for (genvar i = 0; i < RootBits; i++) begin : g_sqrt
    logic [RootBits+3:0] trem;
    logic [RootBits+3:0] trial;
    logic                ge;
    logic [RootBits+3:0] nrem;

    always_comb begin
      trem  = {srem_q[i], srad_q[i][RadBits-1:RadBits-2]};
      trial = (RootBits + 4)'({sroot_q[i], 2'b01});
      ge    = trem >= trial;
      nrem  = ge ? trem - trial : trem;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        srad_q[i+1]  <= srad_q[i] << 2;
        sroot_q[i+1] <= {sroot_q[i][RootBits-2:0], ge};
        srem_q[i+1]  <= nrem[RootBits+1:0];
        spart_q[i+1] <= spart_q[i];
      end
    end
  end

  // Output register with saturation
  logic [RootBits+DistBits-1:0] root_ext;
  assign root_ext = (RootBits + DistBits)'(sroot_q[RootBits]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg_distance_o <= (root_ext > (RootBits + DistBits)'(DistMax))
                        ? DistMax : root_ext[DistBits-1:0];
      nearest_part_o <= spart_q[RootBits];
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      dv_q[0] <= 1'b0;
      sv_q[0] <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      dv_q[0] <= v5_q;
      sv_q[0] <= dv_q[QuoBits];
      out_valid_o <= sv_q[RootBits];
    end
  end

  for (genvar k = 0; k < QuoBits; k++) begin : g_dv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_q[k+1] <= dv_q[k];
      end
    end
  end

  for (genvar i = 0; i < RootBits; i++) begin : g_sv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i+1] <= 1'b0;
      end else if (adv) begin
        sv_q[i+1] <= sv_q[i];
      end
    end
  end

  `PTSD_ASSERT_NOW(a_part_code, out_valid_o, nearest_part_o != 2'd3)
  `PTSD_ASSERT_NOW(a_perp_len, v4_q && side4_q.part == PartPerp, len2_4_q != '0)
  `PTSD_ASSERT_NEXT(a_stall_hold, !adv, $stable(sv_q[RootBits]) && $stable(seg_distance_o))

endmodule
